@@ src/lpe_pkg.sv @@
// ----------------------------------------------------------------------------
// lpe_pkg: shared types and constants of the packet echo
// Buffer sizing, the descriptor between the receive and transmit sides,
// and the packet store port groups.
// ----------------------------------------------------------------------------
package lpe_pkg;

	localparam int BUFFER_BYTES = 64;
	localparam int HEADER_BYTES = 4;
	localparam int LENGTH_INDEX = 3;
	localparam int NUM_BANKS    = 2;

	localparam int BYTE_W   = 8;
	localparam int FILL_W   = 9;
	localparam int MAX_FILL = 255 + HEADER_BYTES;
	localparam int ADDR_W   = $clog2(BUFFER_BYTES);
	localparam int CNT_W    = $clog2(BUFFER_BYTES + 1);
	localparam int BANK_W   = $clog2(NUM_BANKS);
	localparam int RAM_AW   = ADDR_W + BANK_W;
	localparam int RAM_DEPTH = 2 ** RAM_AW;

	// one finished packet waiting for echo
	typedef struct packed {
		logic [BANK_W-1:0] bank;
		logic [CNT_W-1:0]  count;
		logic              trunc;
	} desc_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
		logic [BYTE_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
	} ram_rd_t;

endpackage

@@ src/lpe_ram.sv @@
// ----------------------------------------------------------------------------
// lpe_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lpe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data when no read is issued
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/lpe_desc_fifo.sv @@
// ----------------------------------------------------------------------------
// lpe_desc_fifo: packet descriptor queue
// One entry per store bank; full means every bank holds an unsent packet.
// ----------------------------------------------------------------------------
module lpe_desc_fifo import lpe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	input  logic  pop,
	output desc_t head,
	output logic  full,
	output logic  empty
);

	localparam int PTR_W = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
	localparam int QCNT_W = $clog2(NUM_BANKS + 1);

	desc_t             entry_q [NUM_BANKS];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(NUM_BANKS - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full  = (count_q == QCNT_W'(NUM_BANKS));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("descriptor pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("descriptor popped from an empty queue");
`endif

endmodule

@@ src/lpe_front.sv @@
// ----------------------------------------------------------------------------
// lpe_front: receive side of the packet echo
// Hunts for the start byte, stores the packet, tracks the length field and
// hands a descriptor to the transmit side when the packet is complete.
// ----------------------------------------------------------------------------
module lpe_front import lpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [BYTE_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              q_full,
	output logic              push,
	output desc_t             push_desc,
	output ram_wr_t           wr
);

	logic [FILL_W-1:0] fill_q;
	logic [BYTE_W-1:0] len_q;
	logic [BYTE_W-1:0] start_q;
	logic [BANK_W-1:0] bank_q;

	logic              accept;
	logic              hunting;
	logic [FILL_W-1:0] fill_nxt;
	logic [BYTE_W-1:0] len_eff;
	logic [FILL_W-1:0] total;
	logic              trunc;

	assign cfg_ready = 1'b1;
	// the bank under fill is free whenever the queue has room
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign hunting   = (fill_q == '0);
	assign fill_nxt  = fill_q + FILL_W'(1);
	assign len_eff   = (fill_q == FILL_W'(LENGTH_INDEX)) ? in_byte : len_q;
	assign total     = FILL_W'(len_eff) + FILL_W'(HEADER_BYTES);
	assign trunc     = (total > FILL_W'(BUFFER_BYTES));

	assign push            = accept && !hunting && (fill_nxt == total);
	assign push_desc.bank  = bank_q;
	assign push_desc.count = trunc ? CNT_W'(BUFFER_BYTES) : total[CNT_W-1:0];
	assign push_desc.trunc = trunc;

	// drop bytes beyond the store, keep counting them
	assign wr.en   = accept && (hunting ? (in_byte == start_q)
	                                    : (fill_q < FILL_W'(BUFFER_BYTES)));
	assign wr.addr = {bank_q, fill_q[ADDR_W-1:0]};
	assign wr.data = in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			len_q   <= '0;
			start_q <= '0;
			bank_q  <= '0;
		end else begin
			if (cfg_valid) begin
				start_q <= cfg_data;
			end
			if (accept) begin
				if (hunting) begin
					if (in_byte == start_q) begin
						fill_q <= FILL_W'(1);
					end
				end else if (push) begin
					fill_q <= '0;
					bank_q <= (bank_q == BANK_W'(NUM_BANKS - 1)) ? '0 : bank_q + BANK_W'(1);
				end else begin
					fill_q <= fill_nxt;
				end
				if (fill_q == FILL_W'(LENGTH_INDEX)) begin
					len_q <= in_byte;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_FILL))
		else $error("fill position ran past the longest packet");
`endif

endmodule

@@ src/lpe_back.sv @@
// ----------------------------------------------------------------------------
// lpe_back: transmit side of the packet echo
// Reads the oldest finished packet out of the store and streams it with
// the last and truncation marks.
// ----------------------------------------------------------------------------
module lpe_back import lpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  desc_t             q_head,
	output logic              q_pop,
	output ram_rd_t           rd,
	input  logic [BYTE_W-1:0] rd_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last,
	output logic              out_trunc
);

	logic [ADDR_W-1:0] idx_q;
	logic              valid_s1;
	logic              last_s1;
	logic              trunc_s1;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              trunc_q;

	logic adv_s1;
	logic issue;
	logic last_rd;

	// read data register holds while stage 1 waits
	assign adv_s1  = valid_s1 && (!valid_q || out_ready);
	assign issue   = !q_empty && (!valid_s1 || adv_s1);
	assign last_rd = ((CNT_W'(idx_q) + CNT_W'(1)) == q_head.count);

	assign rd.en   = issue;
	assign rd.addr = {q_head.bank, idx_q};
	assign q_pop   = issue && last_rd;

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_trunc = trunc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			trunc_s1 <= 1'b0;
			valid_q  <= 1'b0;
			byte_q   <= '0;
			last_q   <= 1'b0;
			trunc_q  <= 1'b0;
		end else begin
			if (issue) begin
				idx_q    <= last_rd ? '0 : idx_q + ADDR_W'(1);
				valid_s1 <= 1'b1;
				last_s1  <= last_rd;
				trunc_s1 <= q_head.trunc;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_q <= 1'b1;
				byte_q  <= rd_data;
				last_q  <= last_s1;
				trunc_q <= trunc_s1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		issue |=> (valid_s1 && (last_s1 == $past(q_pop))))
		else $error("last mark and descriptor release out of step");
`endif

endmodule

@@ src/length_prefixed_packet_echo.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_packet_echo: start-byte / length-field framer with echo
// Frames packets out of a byte stream and sends each one back whole.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries received bytes, one item per accepted handshake. While
//   hunting, every byte other than the start byte is dropped. The start byte
//   opens a packet; byte 3 is the unsigned payload length and the packet ends
//   after length + 4 bytes.
//   m_axis echoes each finished packet byte by byte, tlast on the final byte,
//   tuser set on every byte of a packet longer than the store, whose echo
//   holds only the first BUFFER_BYTES bytes.
//   cfg writes the start byte (cfg_ready always high); write it only when idle.
// Timing:
//   The receive side takes one byte per cycle. The store has two banks, so a
//   packet can be received while the previous one is echoed; s_axis stalls
//   only when both banks hold packets not yet fully read out.
//   The first echoed byte reaches m_axis through stage 1 and the output
//   register once the last byte of a packet is taken; then one byte per cycle,
//   set by the single store read port, as long as the receiver takes them.
// Reset: arst_n clears the framer to hunting, the start byte to 0 and empties
//   the queue and output register. The store itself is not cleared.
// Stall: a stalled receiver holds the output register, stage 1 behind it.
// ----------------------------------------------------------------------------
module length_prefixed_packet_echo import lpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration: start_byte[7:0]
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [BYTE_W-1:0] cfg_data,
	// receive stream
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] rx_byte
	// echo stream
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [BYTE_W-1:0] m_axis_tdata,   // [7:0] tx_byte
	output logic              m_axis_tlast,   // last_of_packet
	output logic              m_axis_tuser    // [0] truncated
);

	logic    q_full;
	logic    q_empty;
	logic    push;
	logic    pop;
	desc_t   push_desc;
	desc_t   head;
	ram_wr_t wr;
	ram_rd_t rd;
	logic [BYTE_W-1:0] rd_data;

	// receive side: hunt, store, count
	lpe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc),
		.wr        (wr)
	);

	// finished packets waiting for echo, one per bank
	lpe_desc_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// packet store, two banks of BUFFER_BYTES
	lpe_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd.en),
		.raddr (rd.addr),
		.rdata (rd_data)
	);

	// transmit side: read out and stream
	lpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (head),
		.q_pop     (pop),
		.rd        (rd),
		.rd_data   (rd_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_trunc (m_axis_tuser)
	);

endmodule
